>>> hw/rtl/ps2mc_pkg.sv
package ps2mc_pkg;

   // Register indexes on the configuration port
   typedef enum logic [0:0] {
      CSR_MAX_COL = 1'b0,
      CSR_MAX_ROW = 1'b1
   } csr_index_type;

   localparam logic [7:0] MAX_COL_RESET = 8'd79;
   localparam logic [7:0] MAX_ROW_RESET = 8'd24;

   // Head byte bits that carry the buttons
   localparam int unsigned BUTTON_BITS = 3;

   // Place of the next byte within a packet
   typedef enum logic [2:0] {
      POS_HEAD = 3'b001,
      POS_DX   = 3'b010,
      POS_DY   = 3'b100
   } byte_pos_type;

   // One decoded packet
   typedef struct packed {
      logic [7:0]             old_col;
      logic [7:0]             old_row;
      logic [7:0]             new_col;
      logic [7:0]             new_row;
      logic [BUTTON_BITS-1:0] button_state;
      logic [BUTTON_BITS-1:0] button_changed;
   } result_type;

endpackage

>>> hw/rtl/ps2mc_move.sv
module ps2mc_move (
   input  logic [7:0]                     cursor_col,
   input  logic [7:0]                     cursor_row,
   input  logic [7:0]                     packet_head,
   input  logic [7:0]                     packet_dx,
   input  logic [7:0]                     packet_dy,
   input  logic [ps2mc_pkg::BUTTON_BITS-1:0] last_buttons,
   input  logic [7:0]                     max_col,
   input  logic [7:0]                     max_row,
   output ps2mc_pkg::result_type          result
);
   import ps2mc_pkg::*;

   logic signed [9:0] col_sum;
   logic signed [9:0] row_sum;
   logic [7:0]        col_clamped;
   logic [7:0]        row_clamped;
   logic [BUTTON_BITS-1:0] buttons;

   // Move on the full-width sum; row grows downward so subtract Y
   assign col_sum = $signed({2'b00, cursor_col}) + $signed({{2{packet_dx[7]}}, packet_dx});
   assign row_sum = $signed({2'b00, cursor_row}) - $signed({{2{packet_dy[7]}}, packet_dy});

   // Clamp both axes to the screen bounds
   always_comb begin
      if (col_sum < 0) begin
         col_clamped = 8'd0;
      end else if (col_sum > $signed({2'b00, max_col})) begin
         col_clamped = max_col;
      end else begin
         col_clamped = col_sum[7:0];
      end
      if (row_sum < 0) begin
         row_clamped = 8'd0;
      end else if (row_sum > $signed({2'b00, max_row})) begin
         row_clamped = max_row;
      end else begin
         row_clamped = row_sum[7:0];
      end
   end

   assign buttons = packet_head[BUTTON_BITS-1:0];

   always_comb begin
      result.old_col        = cursor_col;
      result.old_row        = cursor_row;
      result.new_col        = col_clamped;
      result.new_row        = row_clamped;
      result.button_state   = buttons;
      result.button_changed = buttons ^ last_buttons;
   end

endmodule

>>> hw/rtl/ps2_mouse_packet_cursor.sv
// PS/2 mouse packet decoder driving a text cursor.
//
// Request channel (req_valid/req_ready): one byte from the aux port per
// request, with req_from_mouse set when it came from the mouse. Bytes
// without the flag are dropped. Flagged bytes form head, X, Y packets.
// Response channel (rsp_valid/rsp_ready): one response per completed
// packet with the old and new cursor position (clamped to max_col and
// max_row), the button bits and the mask of buttons that changed.
// Configuration: csr_wr_en writes csr_wdata into the register at
// csr_index (0 max_col, 1 max_row) at the clock edge; write only while idle.
//
// Each response passes the input register and then the response register.
// Throughput: one request per cycle while no response stalls; the input
// and response registers form two stages and both advance in the same cycle.
// Reset: cursor at column 0, row 0, buttons released, max_col 79,
// max_row 24, packet restarts with a head byte.
// Stall: while a response waits for rsp_ready, one more byte is held in
// the input register; bytes that make no response keep flowing.
module ps2_mouse_packet_cursor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_from_mouse,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_old_col,
   output logic [7:0] rsp_old_row,
   output logic [7:0] rsp_new_col,
   output logic [7:0] rsp_new_row,
   output logic [ps2mc_pkg::BUTTON_BITS-1:0] rsp_button_state,
   output logic [ps2mc_pkg::BUTTON_BITS-1:0] rsp_button_changed,
   input  logic       csr_wr_en,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import ps2mc_pkg::*;

   logic         in_valid_ff;
   logic         in_mouse_ff;
   logic [7:0]   in_byte_ff;

   byte_pos_type pos_ff, pos_in;
   logic [7:0]   head_ff;
   logic [7:0]   dx_ff;
   logic [7:0]   col_ff, col_in;
   logic [7:0]   row_ff, row_in;
   logic [BUTTON_BITS-1:0] last_btn_ff, last_btn_in;
   logic [7:0]   max_col_ff;
   logic [7:0]   max_row_ff;

   logic         rsp_valid_ff;
   result_type   rsp_ff;
   result_type   result;

   logic         emit;
   logic         out_free;
   logic         advance;
   logic         take_mouse;

   // Handshake between the two stages
   assign emit       = in_valid_ff && in_mouse_ff && (pos_ff == POS_DY);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = in_valid_ff && (out_free || !emit);
   assign take_mouse = advance && in_mouse_ff;
   assign req_ready  = !in_valid_ff || advance;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_mouse_ff <= req_from_mouse;
         in_byte_ff  <= req_data_byte;
      end
   end

   // Packet and cursor arithmetic
   ps2mc_move u_move (
      .cursor_col   (col_ff),
      .cursor_row   (row_ff),
      .packet_head  (head_ff),
      .packet_dx    (dx_ff),
      .packet_dy    (in_byte_ff),
      .last_buttons (last_btn_ff),
      .max_col      (max_col_ff),
      .max_row      (max_row_ff),
      .result       (result)
   );

   // Next packet position and cursor state
   always_comb begin
      pos_in      = pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      last_btn_in = last_btn_ff;
      case (pos_ff)
         POS_DX: begin
            pos_in = POS_DY;
         end
         POS_DY: begin
            pos_in      = POS_HEAD;
            col_in      = result.new_col;
            row_in      = result.new_row;
            last_btn_in = result.button_state;
         end
         default: begin
            pos_in = POS_DX;
         end
      endcase
   end

   // Advance state on a mouse byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HEAD;
         col_ff      <= 8'd0;
         row_ff      <= 8'd0;
         last_btn_ff <= '0;
      end else if (take_mouse) begin
         pos_ff      <= pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_btn_ff <= last_btn_in;
      end
   end

   // Hold the head and X bytes of the packet
   always_ff @(posedge clock) begin
      if (take_mouse && (pos_ff == POS_DX)) begin
         dx_ff <= in_byte_ff;
      end
      if (take_mouse && (pos_ff != POS_DX) && (pos_ff != POS_DY)) begin
         head_ff <= in_byte_ff;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_col_ff <= MAX_COL_RESET;
         max_row_ff <= MAX_ROW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_COL: max_col_ff <= csr_wdata;
            CSR_MAX_ROW: max_row_ff <= csr_wdata;
            default: begin
               max_col_ff <= max_col_ff;
            end
         endcase
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
      if (out_free && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_old_col        = rsp_ff.old_col;
   assign rsp_old_row        = rsp_ff.old_row;
   assign rsp_new_col        = rsp_ff.new_col;
   assign rsp_new_row        = rsp_ff.new_row;
   assign rsp_button_state   = rsp_ff.button_state;
   assign rsp_button_changed = rsp_ff.button_changed;

endmodule

>>> hw/rtl/ps2mc_checker.sv
module ps2mc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_old_col,
   input logic [7:0] rsp_old_row,
   input logic [7:0] rsp_new_col,
   input logic [7:0] rsp_new_row,
   input logic [ps2mc_pkg::BUTTON_BITS-1:0] rsp_button_state,
   input logic [ps2mc_pkg::BUTTON_BITS-1:0] rsp_button_changed,
   input logic       csr_wr_en,
   input logic [0:0] csr_index,
   input logic [7:0] csr_wdata
);
   import ps2mc_pkg::*;

   logic [7:0]             max_col_ff;
   logic [7:0]             max_row_ff;
   logic [7:0]             last_col_ff;
   logic [7:0]             last_row_ff;
   logic [BUTTON_BITS-1:0] last_btn_ff;

   // Shadow the bounds written on the configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         max_col_ff <= MAX_COL_RESET;
         max_row_ff <= MAX_ROW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_COL: max_col_ff <= csr_wdata;
            CSR_MAX_ROW: max_row_ff <= csr_wdata;
            default: begin
               max_col_ff <= max_col_ff;
            end
         endcase
      end
   end

   // Track the last delivered position and buttons
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= 8'd0;
         last_row_ff <= 8'd0;
         last_btn_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_col_ff <= rsp_new_col;
         last_row_ff <= rsp_new_row;
         last_btn_ff <= rsp_button_state;
      end
   end

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_col) && $stable(rsp_new_row))
      else $error("stalled response changed");

   // New position stays within the bounds
   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_col <= max_col_ff) && (rsp_new_row <= max_row_ff))
      else $error("cursor outside bounds");

   // Each packet starts where the previous one ended
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_old_col == last_col_ff) && (rsp_old_row == last_row_ff))
      else $error("old position does not match previous response");

   // Change mask follows the previous buttons
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_button_changed == (rsp_button_state ^ last_btn_ff))
      else $error("button change mask wrong");

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_ps2mc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_old_col        (rsp_old_col),
   .rsp_old_row        (rsp_old_row),
   .rsp_new_col        (rsp_new_col),
   .rsp_new_row        (rsp_new_row),
   .rsp_button_state   (rsp_button_state),
   .rsp_button_changed (rsp_button_changed),
   .csr_wr_en          (csr_wr_en),
   .csr_index          (csr_index),
   .csr_wdata          (csr_wdata)
);

>>> tb/tb_ps2_mouse_packet_cursor.sv
module tb_ps2_mouse_packet_cursor;
   import ps2mc_pkg::*;

   localparam int NUM_DIRECTED = 22;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 190;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTED  = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_from_mouse = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_old_col;
   logic [7:0] rsp_old_row;
   logic [7:0] rsp_new_col;
   logic [7:0] rsp_new_row;
   logic [BUTTON_BITS-1:0] rsp_button_state;
   logic [BUTTON_BITS-1:0] rsp_button_changed;
   logic       csr_wr_en = 1'b0;
   logic [0:0] csr_index = CSR_MAX_COL;
   logic [7:0] csr_wdata = 8'h00;

   ps2_mouse_packet_cursor uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_from_mouse     (req_from_mouse),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_old_col        (rsp_old_col),
      .rsp_old_row        (rsp_old_row),
      .rsp_new_col        (rsp_new_col),
      .rsp_new_row        (rsp_new_row),
      .rsp_button_state   (rsp_button_state),
      .rsp_button_changed (rsp_button_changed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Tracked copy of the decoder state and bounds
   byte_pos_type trk_pos;
   logic [7:0]   trk_head;
   logic [7:0]   trk_dx;
   logic [7:0]   trk_col;
   logic [7:0]   trk_row;
   logic [BUTTON_BITS-1:0] trk_buttons;
   logic [7:0]   lim_col;
   logic [7:0]   lim_row;

   result_type pending_moves[$];
   result_type want_move;
   int         err_count = 0;
   bit         quiet = 1'b0;
   int         ready_hold = 0;

   typedef struct {
      bit         from_mouse;
      logic [7:0] data;
      bit         typed;
      result_type move;
   } dir_row_type;

   // Directed bytes; typed moves start from reset bounds 79 x 24
   dir_row_type dir_tbl [NUM_DIRECTED] = '{
      '{1'b1, 8'h07, 1'b0, '0},
      '{1'b1, 8'h7F, 1'b0, '0},
      '{1'b1, 8'h80, 1'b1, '{8'd0, 8'd0, 8'd79, 8'd24, 3'd7, 3'd7}},
      '{1'b0, 8'hFF, 1'b0, '0},
      '{1'b1, 8'hF8, 1'b0, '0},
      '{1'b1, 8'h80, 1'b0, '0},
      '{1'b1, 8'h7F, 1'b1, '{8'd79, 8'd24, 8'd0, 8'd0, 3'd0, 3'd7}},
      '{1'b1, 8'h01, 1'b0, '0},
      '{1'b1, 8'h00, 1'b0, '0},
      '{1'b1, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 3'd1, 3'd1}},
      '{1'b1, 8'h02, 1'b0, '0},
      '{1'b0, 8'h55, 1'b0, '0},
      '{1'b1, 8'h05, 1'b0, '0},
      '{1'b0, 8'hAA, 1'b0, '0},
      '{1'b1, 8'hFD, 1'b1, '{8'd0, 8'd0, 8'd5, 8'd3, 3'd2, 3'd3}},
      '{1'b1, 8'h04, 1'b0, '0},
      '{1'b1, 8'h01, 1'b0, '0},
      '{1'b1, 8'hFF, 1'b1, '{8'd5, 8'd3, 8'd6, 8'd4, 3'd4, 3'd6}},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b1, 8'h03, 1'b0, '0},
      '{1'b1, 8'h0A, 1'b0, '0},
      '{1'b1, 8'hF6, 1'b0, '0}
   };

   // Bound settings per random phase; the extremes come first
   logic [7:0] phase_col [NUM_PHASES];
   logic [7:0] phase_row [NUM_PHASES];

   task automatic report(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic logic [7:0] clamp_coord(input int v, input logic [7:0] hi);
      if (v < 0)
         return 8'd0;
      if (v > int'(hi))
         return hi;
      return v[7:0];
   endfunction

   // Advance the tracked decoder by one byte; flag a completed packet
   task automatic decode_cursor_move(input bit from_mouse, input logic [7:0] data,
                                     output bit done, output result_type move);
      done = 1'b0;
      move = '0;
      if (from_mouse) begin
         case (trk_pos)
            POS_DX: begin
               trk_dx  = data;
               trk_pos = POS_DY;
            end
            POS_DY: begin
               move.old_col        = trk_col;
               move.old_row        = trk_row;
               move.new_col        = clamp_coord(int'(trk_col) + int'(signed'(trk_dx)),
                                                 lim_col);
               move.new_row        = clamp_coord(int'(trk_row) - int'(signed'(data)),
                                                 lim_row);
               move.button_state   = trk_head[BUTTON_BITS-1:0];
               move.button_changed = trk_head[BUTTON_BITS-1:0] ^ trk_buttons;
               trk_col     = move.new_col;
               trk_row     = move.new_row;
               trk_buttons = move.button_state;
               trk_pos     = POS_HEAD;
               done        = 1'b1;
            end
            default: begin
               trk_head = data;
               trk_pos  = POS_DX;
            end
         endcase
      end
   endtask

   // Offer one request, with an optional idle burst first, and hold until taken
   task automatic send_req(input bit from_mouse, input logic [7:0] data,
                           input bit typed, input result_type typed_move);
      bit         done;
      result_type move;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_from_mouse <= from_mouse;
      req_data_byte  <= data;
      do @(posedge clock); while (!req_ready);
      decode_cursor_move(from_mouse, data, done, move);
      if (typed && !done)
         report("directed row expects a move but the packet is not complete");
      if (done)
         pending_moves.push_back(typed ? typed_move : move);
   endtask

   // Drop valid and let every pending move come out
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one bound, then release the write enable
   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAX_COL)
         lim_col = value;
      else
         lim_row = value;
      @(posedge clock);
   endtask

   // Response side: stall in random bursts, never in the quiet tail
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && $urandom_range(0, 2) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(1, 9);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(1, 30);
      end
   end

   // Check each response against the oldest pending move
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_moves.size() == 0) begin
            report("response with no move pending");
         end else begin
            want_move = pending_moves.pop_front();
            cmp_field("old_col", rsp_old_col, want_move.old_col);
            cmp_field("old_row", rsp_old_row, want_move.old_row);
            cmp_field("new_col", rsp_new_col, want_move.new_col);
            cmp_field("new_row", rsp_new_row, want_move.new_row);
            cmp_field("button_state", 8'(rsp_button_state), 8'(want_move.button_state));
            cmp_field("button_changed", 8'(rsp_button_changed),
                      8'(want_move.button_changed));
         end
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit         from_mouse;
      logic [7:0] data;
      int         pick;

      trk_pos     = POS_HEAD;
      trk_head    = 8'h00;
      trk_dx      = 8'h00;
      trk_col     = 8'd0;
      trk_row     = 8'd0;
      trk_buttons = '0;
      lim_col     = MAX_COL_RESET;
      lim_row     = MAX_ROW_RESET;

      phase_col[0] = 8'd0;    phase_row[0] = 8'd0;
      phase_col[1] = 8'd255;  phase_row[1] = 8'd255;
      phase_col[2] = 8'd3;    phase_row[2] = 8'd2;
      phase_col[3] = 8'd255;  phase_row[3] = 8'd0;
      for (int p = 4; p < NUM_PHASES; p++) begin
         phase_col[p] = 8'($urandom_range(0, 255));
         phase_row[p] = 8'($urandom_range(0, 255));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset bounds
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_req(dir_tbl[i].from_mouse, dir_tbl[i].data, dir_tbl[i].typed,
                  dir_tbl[i].move);

      // Random phases, each under its own bounds
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_csr(CSR_MAX_COL, phase_col[p]);
         write_csr(CSR_MAX_ROW, phase_row[p]);
         if (p == NUM_PHASES - 1)
            quiet = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            from_mouse = ($urandom_range(0, 6) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
               data = 8'h7F;
            else if (pick == 1)
               data = 8'h80;
            else if (pick <= 5)
               data = 8'($urandom_range(0, 6)) - 8'd3;
            else
               data = 8'($urandom_range(0, 255));
            send_req(from_mouse, data, 1'b0, '0);
         end
      end

      drain();
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ps2mc_pkg.sv
hw/rtl/ps2mc_move.sv
hw/rtl/ps2_mouse_packet_cursor.sv
hw/rtl/ps2mc_checker.sv
tb/tb_ps2_mouse_packet_cursor.sv
